// File: rtl/ssst_pkg.sv
// shared constants and types for the small set store
package ssst_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VALUE_W  = 32;
	localparam int FUNC_W   = 2;
	localparam int MCOUNT_W = 5;

	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;

	// control broadcast along the chain of cells
	typedef struct packed {
		logic               cmp_en;
		logic               load_en;
		logic               shift_en;
		logic [VALUE_W-1:0] key;
		logic [CNT_W-1:0]   count;
	} ssst_ctrl_t;

endpackage

// File: rtl/ssst_req_if.sv
// request channel: operation and value
interface ssst_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [ssst_pkg::FUNC_W-1:0]          func;
	logic signed [ssst_pkg::VALUE_W-1:0]  element_value;

	modport source (output valid, output func, output element_value, input ready);
	modport sink (input valid, input func, input element_value, output ready);
endinterface

// File: rtl/ssst_rsp_if.sv
// response channel: membership, count and flags
interface ssst_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          was_present;
	logic [ssst_pkg::MCOUNT_W-1:0] member_count;
	logic                          set_full;
	logic                          set_empty;
	logic                          insert_rejected;

	modport source (output valid, output was_present, output member_count,
		output set_full, output set_empty, output insert_rejected, input ready);
	modport sink (input valid, input was_present, input member_count,
		input set_full, input set_empty, input insert_rejected, output ready);
endinterface

// File: rtl/ssst_cell.sv
// one storage cell of the set: holds a value, compares it and shifts it down
module ssst_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ssst_pkg::ssst_ctrl_t          ctrl,
	input  logic [ssst_pkg::CNT_W-1:0]    idx,
	input  logic [ssst_pkg::VALUE_W-1:0]  next_value,
	input  logic                          hit_in,
	output logic                          hit_out,
	output logic [ssst_pkg::VALUE_W-1:0]  value
);

	logic [ssst_pkg::VALUE_W-1:0] value_q;
	logic                         match_q;

	// match only counts for occupied positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.cmp_en) begin
			match_q <= (value_q == ctrl.key) && (idx < ctrl.count);
		end
	end

	// a delete pulls the neighbour's value into every cell at or above the hit
	always_ff @(posedge clk) begin
		if (ctrl.load_en && (idx == ctrl.count)) begin
			value_q <= ctrl.key;
		end else if (ctrl.shift_en && (hit_in || match_q)) begin
			value_q <= next_value;
		end
	end

	assign hit_out = hit_in || match_q;
	assign value   = value_q;

endmodule

// File: rtl/small_set_store.sv
// Small set store: holds up to CAPACITY distinct 32-bit values in a row of cells, packed in order
// of insertion. Each request inserts, deletes or looks up one value and yields one response.
// A request runs in an accept step and an update step: at the accept edge every cell compares
// its value against the key; in the update step the hit chain settles, the insert or the
// shift-down is applied and the response is registered. The update step waits while a previous
// response is still held, and a new request is taken only once the last one has been updated.
// The store needs no clearing after reset; only positions below the count are ever matched.
module small_set_store (
	input  logic       clk,
	input  logic       arst_n,
	ssst_req_if.sink   req,
	ssst_rsp_if.source rsp
);

	typedef enum logic {ST_IDLE, ST_UPDATE} state_t;

	state_t                        state_q;
	logic [ssst_pkg::FUNC_W-1:0]   func_q;
	logic [ssst_pkg::VALUE_W-1:0]  key_q;
	logic [ssst_pkg::CNT_W-1:0]    count_q;

	logic                          rsp_valid_q;
	logic                          was_present_q;
	logic [ssst_pkg::MCOUNT_W-1:0] member_count_q;
	logic                          set_full_q;
	logic                          set_empty_q;
	logic                          insert_rejected_q;

	ssst_pkg::ssst_ctrl_t          ctrl;
	logic [ssst_pkg::CAPACITY:0]   hit;
	logic [ssst_pkg::VALUE_W-1:0]  cell_value [ssst_pkg::CAPACITY];

	logic                          accept;
	logic                          fire;
	logic                          present;
	logic                          full;
	logic                          is_ins;
	logic                          is_del;
	logic                          rejected;
	logic [ssst_pkg::CNT_W-1:0]    next_count;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign fire      = (state_q == ST_UPDATE) && (!rsp_valid_q || rsp.ready);

	assign present  = hit[ssst_pkg::CAPACITY];
	assign full     = (count_q == ssst_pkg::CNT_W'(ssst_pkg::CAPACITY));
	assign is_ins   = (func_q == ssst_pkg::FN_INSERT);
	assign is_del   = (func_q == ssst_pkg::FN_DELETE);
	assign rejected = is_ins && !present && full;

	always_comb begin
		next_count = count_q;
		if (is_ins && !present && !full) begin
			next_count = count_q + ssst_pkg::CNT_W'(1);
		end else if (is_del && present) begin
			next_count = count_q - ssst_pkg::CNT_W'(1);
		end
	end

	always_comb begin
		ctrl.cmp_en   = accept;
		ctrl.load_en  = fire && is_ins && !present && !full;
		ctrl.shift_en = fire && is_del && present;
		ctrl.key      = (state_q == ST_IDLE) ? req.element_value : key_q;
		ctrl.count    = count_q;
	end

	assign hit[0] = 1'b0;

	for (genvar i = 0; i < ssst_pkg::CAPACITY; i++) begin : g_cell
		logic [ssst_pkg::VALUE_W-1:0] nbr_value;

		if (i == ssst_pkg::CAPACITY - 1) begin : g_last
			assign nbr_value = key_q;
		end else begin : g_mid
			assign nbr_value = cell_value[i+1];
		end

		ssst_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.idx        (ssst_pkg::CNT_W'(i)),
			.next_value (nbr_value),
			.hit_in     (hit[i]),
			.hit_out    (hit[i+1]),
			.value      (cell_value[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			func_q            <= '0;
			key_q             <= '0;
			count_q           <= '0;
			rsp_valid_q       <= 1'b0;
			was_present_q     <= 1'b0;
			member_count_q    <= '0;
			set_full_q        <= 1'b0;
			set_empty_q       <= 1'b0;
			insert_rejected_q <= 1'b0;
		end else begin
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						func_q  <= req.func;
						key_q   <= req.element_value;
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (fire) begin
						count_q           <= next_count;
						was_present_q     <= present;
						member_count_q    <= ssst_pkg::MCOUNT_W'(next_count);
						set_full_q        <= (next_count == ssst_pkg::CNT_W'(ssst_pkg::CAPACITY));
						set_empty_q       <= (next_count == '0);
						insert_rejected_q <= rejected;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.was_present     = was_present_q;
	assign rsp.member_count    = member_count_q;
	assign rsp.set_full        = set_full_q;
	assign rsp.set_empty       = set_empty_q;
	assign rsp.insert_rejected = insert_rejected_q;

endmodule

// File: rtl/ssst_chk.sv
// port-level checks for the small set store
module ssst_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic                          was_present,
	input logic [ssst_pkg::MCOUNT_W-1:0] member_count,
	input logic                          set_full,
	input logic                          set_empty,
	input logic                          insert_rejected
);

	// one request in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while previous one still in work");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(set_full && set_empty))
		else $error("set reported both full and empty");

	// a rejection only happens on a full set and an absent value
	a_reject_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && insert_rejected) |-> (set_full && !was_present))
		else $error("insert rejected without a full set");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(member_count)))
		else $error("stalled response changed");

endmodule

bind small_set_store ssst_chk u_ssst_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.was_present     (rsp.was_present),
	.member_count    (rsp.member_count),
	.set_full        (rsp.set_full),
	.set_empty       (rsp.set_empty),
	.insert_rejected (rsp.insert_rejected)
);
